FILE: sv/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int DATA_W    = 32;
    localparam int KIND_W    = 4;
    localparam int FRAC_BITS = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD      = 4'd0,
        KIND_SUB      = 4'd1,
        KIND_MUL      = 4'd2,
        KIND_DIV      = 4'd3,
        KIND_INC      = 4'd4,
        KIND_DEC      = 4'd5,
        KIND_MIN      = 4'd6,
        KIND_MAX      = 4'd7,
        KIND_FROM_INT = 4'd8,
        KIND_TO_INT   = 4'd9
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [DATA_W-1:0] res;
        logic              gt;
        logic              lt;
        logic              eq;
        logic              dz;
        logic              neg;
    } side_t;

endpackage

FILE: sv/fpa_div_pipe.sv
// ----------------------------------------------------------------------------
// fpa_div_pipe
// Unsigned restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module fpa_div_pipe #(
    parameter int NUM_W = 40
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  fpa_pkg::side_t            in_side,
    input  logic [NUM_W-1:0]          num,
    input  logic [fpa_pkg::DATA_W-1:0] den,
    output logic                      out_valid,
    output fpa_pkg::side_t            out_side,
    output logic [NUM_W-1:0]          quo
);

    localparam int DW = fpa_pkg::DATA_W;

    logic                 valid_reg [NUM_W];
    fpa_pkg::side_t       side_reg  [NUM_W];
    logic [DW-1:0]        rem_reg   [NUM_W];
    logic [NUM_W-1:0]     nq_reg    [NUM_W];
    logic [DW-1:0]        den_reg   [NUM_W];

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic             v_in;
        fpa_pkg::side_t   side_in;
        logic [DW-1:0]    rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [DW-1:0]    den_in;
        logic [DW:0]      trial;
        logic             fits;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign rem_in  = '0;
            assign nq_in   = num;
            assign den_in  = den;
        end
        else begin : g_next
            assign v_in    = valid_reg[i-1];
            assign side_in = side_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign nq_in   = nq_reg[i-1];
            assign den_in  = den_reg[i-1];
        end

        assign trial = {rem_in, nq_in[NUM_W-1]};
        assign fits  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i] <= side_in;
                den_reg[i]  <= den_in;
                nq_reg[i]   <= {nq_in[NUM_W-2:0], fits};
                if (fits)
                begin
                    rem_reg[i] <= DW'(trial - {1'b0, den_in});
                end
                else
                begin
                    rem_reg[i] <= trial[DW-1:0];
                end
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];
    assign quo       = nq_reg[NUM_W-1];

endmodule

FILE: sv/fixed_point_alu_top.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_top
// Signed fixed-point ALU: add, sub, mul, div, inc, dec, min, max, conversions.
// ----------------------------------------------------------------------------
// Accepts one word per cycle while the output is not stalled.
// Depth is set by the divider, which resolves one quotient bit per stage.
// A stall on the output freezes the whole pipeline; nothing is dropped.
// rst_n clears all valid bits; the data registers are not reset.
module fixed_point_alu_top #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a, operand_b
    input  logic [3:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result
    output logic [3:0]  m_tuser    // greater, less, equal, divide_by_zero
);

    localparam int DW    = fpa_pkg::DATA_W;
    localparam int NUM_W = DW + FRAC_BITS;

    logic en;

    // stage 0: input register
    logic                v0_reg;
    fpa_pkg::kind_t      kind0_reg;
    logic signed [DW-1:0] a0_reg;
    logic signed [DW-1:0] b0_reg;

    // stage 1: simple ops, product, divider operands
    logic                  v1_reg;
    fpa_pkg::side_t        side1_reg;
    logic signed [2*DW-1:0] prod1_reg;
    logic [NUM_W-1:0]      num1_reg;
    logic [DW-1:0]         den1_reg;

    // stage 2: product scaling
    logic             v2_reg;
    fpa_pkg::side_t   side2_reg;
    logic [NUM_W-1:0] num2_reg;
    logic [DW-1:0]    den2_reg;

    // output
    logic             out_v_reg;
    logic [DW-1:0]    res_reg;
    logic [3:0]       flags_reg;

    fpa_pkg::side_t   side1_next;
    fpa_pkg::side_t   side2_next;
    logic [DW-1:0]    amag;
    logic [DW-1:0]    bmag;

    logic             dv_valid;
    fpa_pkg::side_t   dv_side;
    logic [NUM_W-1:0] dv_quo;
    logic [DW-1:0]    q_signed;
    logic [DW-1:0]    res_next;

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    always_comb
    begin
        amag = a0_reg[DW-1] ? DW'(-a0_reg) : a0_reg;
        bmag = b0_reg[DW-1] ? DW'(-b0_reg) : b0_reg;

        side1_next.kind = kind0_reg;
        side1_next.gt   = a0_reg > b0_reg;
        side1_next.lt   = a0_reg < b0_reg;
        side1_next.eq   = a0_reg == b0_reg;
        side1_next.dz   = (kind0_reg == fpa_pkg::KIND_DIV) && (b0_reg == '0);
        side1_next.neg  = a0_reg[DW-1] ^ b0_reg[DW-1];
        case (kind0_reg)
            fpa_pkg::KIND_ADD:      side1_next.res = DW'(a0_reg + b0_reg);
            fpa_pkg::KIND_SUB:      side1_next.res = DW'(a0_reg - b0_reg);
            fpa_pkg::KIND_INC:      side1_next.res = DW'(a0_reg + 1);
            fpa_pkg::KIND_DEC:      side1_next.res = DW'(a0_reg - 1);
            fpa_pkg::KIND_MIN:      side1_next.res = (a0_reg <= b0_reg) ? a0_reg : b0_reg;
            fpa_pkg::KIND_MAX:      side1_next.res = (a0_reg >= b0_reg) ? a0_reg : b0_reg;
            fpa_pkg::KIND_FROM_INT: side1_next.res = a0_reg << FRAC_BITS;
            fpa_pkg::KIND_TO_INT:   side1_next.res = a0_reg >>> FRAC_BITS;
            default:                side1_next.res = '0;
        endcase
    end

    always_comb
    begin
        side2_next = side1_reg;
        if (side1_reg.kind == fpa_pkg::KIND_MUL)
        begin
            side2_next.res = prod1_reg[FRAC_BITS +: DW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= s_tvalid;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            out_v_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind0_reg <= fpa_pkg::kind_t'(s_tuser);
            a0_reg    <= s_tdata[DW-1:0];
            b0_reg    <= s_tdata[2*DW-1:DW];

            side1_reg <= side1_next;
            prod1_reg <= a0_reg * b0_reg;
            num1_reg  <= {amag, {FRAC_BITS{1'b0}}};
            den1_reg  <= bmag;

            side2_reg <= side2_next;
            num2_reg  <= num1_reg;
            den2_reg  <= den1_reg;

            res_reg   <= res_next;
            flags_reg <= {dv_side.dz, dv_side.eq, dv_side.lt, dv_side.gt};
        end
    end

    fpa_div_pipe #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_side   (side2_reg),
        .num       (num2_reg),
        .den       (den2_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .quo       (dv_quo)
    );

    always_comb
    begin
        q_signed = dv_side.neg ? DW'(-dv_quo[DW-1:0]) : dv_quo[DW-1:0];
        if (dv_side.kind == fpa_pkg::KIND_DIV)
        begin
            res_next = dv_side.dz ? '0 : q_signed;
        end
        else
        begin
            res_next = dv_side.res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = res_reg;
    assign m_tuser  = flags_reg;

endmodule
